[sv/crc16fc_pkg.sv]
package crc16fc_pkg;

	// Frame layout and check constants.
	localparam int unsigned HEADER_LEN = 4;
	localparam int unsigned MAX_RESULTS = 64;
	localparam logic [31:0] HEADER_RESET = 32'hAA55_AA55;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Frame status codes, in check order.
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_HDR = 2'd1,
		ST_LEN = 2'd2,
		ST_CRC = 2'd3
	} status_t;

	// One received byte.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic frame_end;
	} rx_item_t;

	// One result.
	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [7:0] out_byte;
		logic run_last;
	} result_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic take;
		logic load_status;
		logic drain_read;
		logic load_payload;
	} cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic out_free;
		logic frame_ok;
		logic no_payload;
		logic last_payload;
	} sts_t;

	// CRC-16/MODBUS over one byte, reflected, bit at a time.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/crc16fc_ram.sv]
module crc16fc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/crc16fc_dp.sv]
module crc16fc_dp
	import crc16fc_pkg::*;
#(
	parameter int FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  rx_item_t    in_item,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_item
);

	localparam int PW = $clog2(FRAME_BYTES + 1);
	localparam int AW = $clog2(FRAME_BYTES);
	localparam int CW = ((PW > 9) ? PW : 9) + 1;

	logic [31:0]   header_pattern_q;
	logic [PW-1:0] pos_q;
	logic          header_good_q;
	logic [7:0]    length_q;
	logic [15:0]   crc_q;
	logic [15:0]   rx_crc_q;
	logic [7:0]    np_q;
	logic [7:0]    idx_q;
	logic          out_valid_q;
	result_t       out_q;

	logic [CW-1:0] pos_x;
	logic [CW-1:0] len_x;
	logic [7:0]    want_byte;
	logic          in_frame;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_rdata;
	status_t       frame_status;
	logic          out_free;

	assign pos_x = CW'(pos_q);
	assign len_x = CW'(length_q);
	assign in_frame = (pos_x < CW'(FRAME_BYTES));

	// Expected header byte for the current position.
	always_comb begin
		unique case (pos_q[1:0])
			2'd0: want_byte = header_pattern_q[31:24];
			2'd1: want_byte = header_pattern_q[23:16];
			2'd2: want_byte = header_pattern_q[15:8];
			default: want_byte = header_pattern_q[7:0];
		endcase
	end

	// Payload bytes go to the store at their offset after the length byte.
	assign ram_we = cmd.take && in_frame && (pos_x > CW'(HEADER_LEN))
		&& (pos_x < CW'(HEADER_LEN) + len_x);
	assign ram_waddr = AW'(pos_x - CW'(HEADER_LEN + 1));

	crc16fc_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(in_item.rx_byte),
		.rd_en(cmd.drain_read),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(ram_rdata)
	);

	// Frame verdict from the registered frame state, first failing check wins.
	always_comb begin
		priority if (!header_good_q) begin
			frame_status = ST_HDR;
		end else if ((pos_x < CW'(HEADER_LEN + 1)) || (length_q == 8'd0)
				|| (len_x + CW'(HEADER_LEN + 2) > CW'(FRAME_BYTES))
				|| (len_x > CW'(MAX_RESULTS))
				|| (pos_x < len_x + CW'(HEADER_LEN + 2))) begin
			frame_status = ST_LEN;
		end else if (rx_crc_q != crc_q) begin
			frame_status = ST_CRC;
		end else begin
			frame_status = ST_OK;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign sts.out_free = out_free;
	assign sts.frame_ok = (frame_status == ST_OK);
	assign sts.no_payload = (length_q == 8'd1);
	assign sts.last_payload = ((idx_q + 8'd1) == np_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pattern_q <= HEADER_RESET;
		end else if (cfg_wr_en) begin
			header_pattern_q <= cfg_wr_data;
		end
	end

	// Frame state: parse each byte, clear once the verdict is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			header_good_q <= 1'b1;
			length_q <= '0;
			crc_q <= CRC_INIT;
			rx_crc_q <= '0;
		end else if (cmd.load_status) begin
			pos_q <= '0;
			header_good_q <= 1'b1;
			length_q <= '0;
			crc_q <= CRC_INIT;
			rx_crc_q <= '0;
		end else if (cmd.take && in_frame) begin
			priority if (pos_x < CW'(HEADER_LEN)) begin
				if (want_byte != in_item.rx_byte) begin
					header_good_q <= 1'b0;
				end
			end else if (pos_x == CW'(HEADER_LEN)) begin
				length_q <= in_item.rx_byte;
				crc_q <= crc_byte(crc_q, in_item.rx_byte);
			end else if (pos_x < CW'(HEADER_LEN) + len_x) begin
				crc_q <= crc_byte(crc_q, in_item.rx_byte);
			end else if (pos_x == CW'(HEADER_LEN) + len_x) begin
				rx_crc_q[15:8] <= in_item.rx_byte;
			end else if (pos_x == CW'(HEADER_LEN + 1) + len_x) begin
				rx_crc_q[7:0] <= in_item.rx_byte;
			end
			pos_q <= pos_q + PW'(1);
		end
	end

	// Drain counters for the payload walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q <= '0;
			idx_q <= '0;
		end else if (cmd.load_status) begin
			np_q <= length_q - 8'd1;
			idx_q <= '0;
		end else if (cmd.load_payload) begin
			idx_q <= idx_q + 8'd1;
		end
	end

	// Output register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_status || cmd.load_payload) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_q.kind <= KIND_STATUS;
			out_q.status <= frame_status;
			out_q.out_byte <= 8'h00;
			out_q.run_last <= (frame_status != ST_OK) || (length_q == 8'd1);
		end else if (cmd.load_payload) begin
			out_q.kind <= KIND_PAYLOAD;
			out_q.status <= ST_OK;
			out_q.out_byte <= ram_rdata;
			out_q.run_last <= ((idx_q + 8'd1) == np_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

[sv/crc16fc_ctrl.sv]
module crc16fc_ctrl
	import crc16fc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  rx_item_t in_item,
	output logic     in_stall,
	input  sts_t     sts,
	output cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;

	// Bytes are taken only while no verdict or drain is in progress.
	assign in_stall = (state_q != S_IDLE);

	// Commands decoded from state and datapath status.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.take = in_valid;
			S_CHECK: cmd.load_status = sts.out_free;
			S_READ: cmd.drain_read = 1'b1;
			S_EMIT: cmd.load_payload = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// Sequencer: parse, verdict, then walk the payload store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_item.frame_end) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.out_free) begin
						state_q <= (sts.frame_ok && !sts.no_payload) ? S_READ : S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= sts.last_payload ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/crc16fc_top.sv]
// CRC-16/MODBUS frame checker. Frame bytes enter one per cycle while a frame
// arrives; the item with frame_end set closes the frame and is followed by one
// status item, and on success by the L-1 payload bytes, the last result of a
// frame carrying run_last. From the end-of-frame item the input is stalled while
// the verdict is formed and while the payload is drained, since each byte comes
// through the registered read port of the payload store before it enters the
// output register; a stalled output lengthens the stall. The output register
// lets the next frame start while the final result is still waiting. The
// payload store needs no clearing pass: only bytes written in the current frame
// are ever read back. The user must write the header pattern only while the
// block is idle; the block itself does not enforce it.
module crc16_frame_checker_top
	import crc16fc_pkg::*;
#(
	parameter int FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  rx_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_item,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	crc16fc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_item(in_item),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	crc16fc_dp #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_item(in_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// A failing verdict ends the run at once.
	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == KIND_STATUS) && (out_item.status != ST_OK)
		|-> out_item.run_last)
		else $error("failing status item without run_last");

	// Payload bytes only follow a good frame.
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == KIND_PAYLOAD) |-> (out_item.status == ST_OK)
		&& (out_item.out_byte == out_item.out_byte))
		else $error("payload item with nonzero status");

	// The end of a frame holds off the next byte while the verdict is formed.
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.frame_end |=> in_stall)
		else $error("input taken right after end of frame");

	// A payload byte is loaded only after a store read.
	a_read_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_payload |-> $past(cmd.drain_read) || $past(cmd.load_payload) == 1'b0
		&& $stable(cmd.load_payload) == 1'b0)
		else $error("payload loaded without a store read");

endmodule

[test/crc16_frame_checker_top_tb.sv]
module crc16_frame_checker_top_tb;
	import crc16fc_pkg::*;

	localparam int FRAME_BYTES = 64;
	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 60;

	// Where a directed byte comes from: the table itself or the running CRC.
	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_CRC_HI,
		SRC_CRC_LO
	} byte_src_t;

	typedef struct packed {
		logic [7:0] b;
		logic fe;
		byte_src_t src;
		logic typed;
		status_t st;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rx_item_t in_item;
	logic out_valid;
	logic out_stall;
	result_t out_item;
	logic cfg_wr_en;
	logic [31:0] cfg_wr_data;

	// Own copy of the frame checker state.
	logic [31:0] header_cfg = HEADER_RESET;
	int fm_pos = 0;
	logic fm_hdr_ok = 1'b1;
	int fm_len = 0;
	logic [15:0] fm_crc = CRC_INIT;
	logic [15:0] fm_rx_crc = 16'h0000;
	logic [7:0] fm_store [FRAME_BYTES];

	result_t pending_results[$];
	result_t step_results[$];
	logic [7:0] frame_q[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	int phase_items = 0;
	bit row_typed = 1'b0;
	status_t row_status = ST_OK;

	// Directed frames: header mismatch, zero length, overlong claim,
	// bad CRC, then one good frame with a single payload byte.
	dir_row_t dir_tab [26] = '{
		'{8'h00, 1'b1, SRC_LIT, 1'b1, ST_HDR},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h00, 1'b1, SRC_LIT, 1'b1, ST_LEN},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hFF, 1'b1, SRC_LIT, 1'b1, ST_LEN},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h01, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h00, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h00, 1'b1, SRC_LIT, 1'b1, ST_CRC},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hAA, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h55, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h02, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'hFF, 1'b0, SRC_LIT, 1'b0, ST_OK},
		'{8'h00, 1'b0, SRC_CRC_HI, 1'b0, ST_OK},
		'{8'h00, 1'b1, SRC_CRC_LO, 1'b0, ST_OK}
	};

	crc16_frame_checker_top #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One step of CRC-16/MODBUS, reflected, one bit at a time.
	function automatic logic [15:0] crc16_modbus_next(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ 16'hA001;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// Advances the frame state by one byte and lists the results it causes.
	task automatic frame_model_byte(input rx_item_t it, ref result_t res[$]);
		int p;
		int n;
		int np;
		logic [7:0] want;
		status_t st;
		res.delete();
		p = fm_pos;
		if (p < FRAME_BYTES) begin
			if (p < HEADER_LEN) begin
				want = header_cfg[31 - 8 * p -: 8];
				if (want != it.rx_byte) begin
					fm_hdr_ok = 1'b0;
				end
			end else if (p == HEADER_LEN) begin
				fm_len = it.rx_byte;
				fm_crc = crc16_modbus_next(fm_crc, it.rx_byte);
			end else if (p < HEADER_LEN + fm_len) begin
				fm_crc = crc16_modbus_next(fm_crc, it.rx_byte);
				fm_store[(p - HEADER_LEN - 1) % FRAME_BYTES] = it.rx_byte;
			end else if (p == HEADER_LEN + fm_len) begin
				fm_rx_crc = {it.rx_byte, 8'h00};
			end else if (p == HEADER_LEN + fm_len + 1) begin
				fm_rx_crc = {fm_rx_crc[15:8], it.rx_byte};
			end
			fm_pos = p + 1;
		end
		if (!it.frame_end) begin
			return;
		end
		n = fm_pos;
		if (!fm_hdr_ok) begin
			st = ST_HDR;
		end else if (n < HEADER_LEN + 1 || fm_len == 0 || fm_len + HEADER_LEN + 2 > FRAME_BYTES
				|| fm_len - 1 > MAX_RESULTS - 1 || n < fm_len + HEADER_LEN + 2) begin
			st = ST_LEN;
		end else if (fm_rx_crc != fm_crc) begin
			st = ST_CRC;
		end else begin
			st = ST_OK;
		end
		if (st != ST_OK) begin
			res.push_back('{kind: KIND_STATUS, status: st, out_byte: 8'h00, run_last: 1'b1});
		end else begin
			np = fm_len - 1;
			res.push_back('{kind: KIND_STATUS, status: ST_OK, out_byte: 8'h00,
				run_last: (np == 0)});
			for (int i = 0; i < np; i++) begin
				res.push_back('{kind: KIND_PAYLOAD, status: ST_OK,
					out_byte: fm_store[i % FRAME_BYTES], run_last: (i + 1 == np)});
			end
		end
		fm_pos = 0;
		fm_hdr_ok = 1'b1;
		fm_len = 0;
		fm_crc = CRC_INIT;
		fm_rx_crc = 16'h0000;
	endtask

	// Result checking, then prediction for an accepted input item.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing expected: %p", out_item);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_item.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_item.kind);
						mismatch_count++;
					end
					if (out_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_item.status);
						mismatch_count++;
					end
					if (out_item.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte,
							out_item.out_byte);
						mismatch_count++;
					end
					if (out_item.run_last !== want.run_last) begin
						$error("run_last: expected %0d, got %0d", want.run_last,
							out_item.run_last);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				frame_model_byte(in_item, step_results);
				if (row_typed) begin
					pending_results.push_back('{kind: KIND_STATUS, status: row_status,
						out_byte: 8'h00, run_last: 1'b1});
				end else begin
					foreach (step_results[i]) begin
						pending_results.push_back(step_results[i]);
					end
				end
			end
			// Watchdog on cycles with no item moving on either side.
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WDOG_LIMIT) begin
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	// Receiver: random stall, or a long hold-off when asked for.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offers one item, with random idle cycles ahead of it, and waits for it to go in.
	task automatic send_item(input rx_item_t it, input bit typed, input status_t st);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		row_typed = typed;
		row_status = st;
		forever begin
			@(posedge clk);
			if (!in_stall) begin
				break;
			end
			@(negedge clk);
		end
		phase_items++;
	endtask

	// Sends the bytes of frame_q, frame_end on the last one.
	task automatic send_frame();
		rx_item_t it;
		foreach (frame_q[i]) begin
			it.rx_byte = frame_q[i];
			it.frame_end = (i == frame_q.size() - 1);
			send_item(it, 1'b0, ST_OK);
		end
	endtask

	// Header, length, payload and CRC of a correct frame.
	task automatic add_good_frame(input int len);
		logic [15:0] c;
		logic [7:0] b;
		c = CRC_INIT;
		for (int i = 0; i < HEADER_LEN; i++) begin
			frame_q.push_back(header_cfg[31 - 8 * i -: 8]);
		end
		frame_q.push_back(len[7:0]);
		c = crc16_modbus_next(c, len[7:0]);
		for (int i = 1; i < len; i++) begin
			b = 8'($urandom_range(255));
			frame_q.push_back(b);
			c = crc16_modbus_next(c, b);
		end
		frame_q.push_back(c[15:8]);
		frame_q.push_back(c[7:0]);
	endtask

	// Mostly correct frames with random content; the rest broken or noise.
	task automatic build_frame();
		int len;
		int n;
		int idx;
		frame_q.delete();
		len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 58);
		if ($urandom_range(99) < 70) begin
			add_good_frame(len);
			if ($urandom_range(99) < 20) begin
				n = $urandom_range(1, 4);
				repeat (n) frame_q.push_back(8'($urandom_range(255)));
			end
		end else begin
			case ($urandom_range(5))
				0: begin
					add_good_frame(len);
					idx = $urandom_range(HEADER_LEN - 1);
					frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
				end
				1: begin
					add_good_frame(len);
					idx = frame_q.size() - 1 - $urandom_range(1);
					frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
				end
				2: begin
					add_good_frame(len);
					n = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > n) frame_q.pop_back();
				end
				3: begin
					for (int i = 0; i < HEADER_LEN; i++) begin
						frame_q.push_back(header_cfg[31 - 8 * i -: 8]);
					end
					frame_q.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(59, 255)));
					n = $urandom_range(0, 10);
					repeat (n) frame_q.push_back(8'($urandom_range(255)));
				end
				4: begin
					add_good_frame($urandom_range(50, 58));
					n = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8);
					while (frame_q.size() < n) frame_q.push_back(8'($urandom_range(255)));
				end
				default: begin
					n = $urandom_range(1, 10);
					repeat (n) frame_q.push_back(8'($urandom_range(255)));
				end
			endcase
		end
	endtask

	// Lets every expected result arrive, then gives the block time to settle.
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_header(input logic [31:0] pat);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= pat;
		header_cfg = pat;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One random phase: new header pattern, new idle and stall rates, about PHASE_ITEMS items.
	task automatic run_phase(input logic [31:0] pat, input int ip, input int sp,
			input bit hold);
		wait_all_results();
		write_header(pat);
		idle_pct = ip;
		stall_pct = sp;
		phase_items = 0;
		if (hold) begin
			// Receiver holds off while long frames keep coming in.
			hold_req = 1'b1;
			repeat (2) begin
				frame_q.delete();
				add_good_frame(40);
				send_frame();
			end
		end
		while (phase_items < PHASE_ITEMS) begin
			build_frame();
			send_frame();
		end
	endtask

	initial begin
		rx_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, under the header pattern left by reset.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].src != SRC_LIT) begin
				// Let the predictor take the previous byte before its CRC is read.
				@(negedge clk);
				in_valid <= 1'b0;
			end
			case (dir_tab[i].src)
				SRC_CRC_HI: it.rx_byte = fm_crc[15:8];
				SRC_CRC_LO: it.rx_byte = fm_crc[7:0];
				default: it.rx_byte = dir_tab[i].b;
			endcase
			it.frame_end = dir_tab[i].fe;
			send_item(it, dir_tab[i].typed, dir_tab[i].st);
		end

		run_phase(HEADER_RESET, 0, 0, 1'b0);
		run_phase(32'h0000_0000, 52, 0, 1'b0);
		run_phase(32'hFFFF_FFFF, 0, 52, 1'b0);
		run_phase($urandom, 23, 23, 1'b1);
		run_phase($urandom, 0, 0, 1'b0);

		wait_all_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
